// ----- sv/lru_victim_heap_defines.svh -----
// Assertion macros shared by the checker of the victim heap
`ifndef LRU_VICTIM_HEAP_DEFINES_SVH
`define LRU_VICTIM_HEAP_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle
`define LVH_ASSERT_NOW(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
		else $error("lru_victim_heap check failed");

// Check that a condition implies a consequence in the following cycle
`define LVH_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
		else $error("lru_victim_heap check failed");

`endif

// ----- sv/lvh_pkg.sv -----
// Shared constants and types of the victim heap
`default_nettype none

package lvh_pkg;

	localparam int NUM_BLOCKS = 1024;
	localparam int BLK_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = BLK_W + 1;
	localparam int STAMP_W    = 32;

	typedef enum logic [1:0] {
		OP_RELEASE = 2'd0,
		OP_TAKE    = 2'd1,
		OP_EVICT   = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

endpackage

`default_nettype wire

// ----- sv/lru_victim_heap.sv -----
// LRU victim selection: binary min-heap of free blocks keyed by last-use stamp
//
// Input channel (in_valid/in_ready) carries op, block_id and stamp_use; output
// channel (out_valid/out_ready) returns victim_id, error and free_count, one
// result item per input item, in order.
// After reset the block runs a clearing pass over all 1024 slots that fills the
// heap with every block in index order at stamp 0; in_ready stays low meanwhile.
// Each item is worked by a small sequencer around one shared age comparator
// and registered-read RAMs: accept, look up, then per level of sift-up a parent
// read, a stamp lookup and a compare, and per level of sift-down a child read,
// a stamp lookup, a child select and a compare, plus a read and a stamp lookup
// of the last heap entry on take and evict, and a hand-over of the result.
// The next item is accepted in the cycle after the result is loaded into the
// output register, while that result may still wait there.
// A stalled receiver holds the result in the output register; the block then
// finishes at most one more item and waits with it until the register frees.
`default_nettype none

module lru_victim_heap import lvh_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         op,
	input  wire logic [BLK_W-1:0]   block_id,
	input  wire logic               stamp_use,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [BLK_W-1:0]   victim_id,
	output logic                    error,
	output logic      [CNT_W-1:0]   free_count
);

	typedef enum logic [12:0] {
		S_INIT    = 13'b0000000000001,
		S_IDLE    = 13'b0000000000010,
		S_CHECK   = 13'b0000000000100,
		S_LAST_RD = 13'b0000000001000,
		S_LAST_LU = 13'b0000000010000,
		S_UP      = 13'b0000000100000,
		S_UP_LU   = 13'b0000001000000,
		S_UP_CMP  = 13'b0000010000000,
		S_DN      = 13'b0000100000000,
		S_DN_LU   = 13'b0001000000000,
		S_DN_SEL  = 13'b0010000000000,
		S_DN_CMP  = 13'b0100000000000,
		S_FIN     = 13'b1000000000000
	} state_t;

	state_t             state_q;
	logic [BLK_W-1:0]   init_idx_q;
	op_t                op_q;
	logic [BLK_W-1:0]   blk_q;
	logic               stamp_q;
	logic [STAMP_W-1:0] use_clock_q;
	logic [CNT_W-1:0]   count_q;
	logic [BLK_W-1:0]   slot_q;
	logic [BLK_W-1:0]   mv_blk_q;
	logic [STAMP_W-1:0] mv_stamp_q;
	logic               removing_q;
	logic               moved_q;
	logic [BLK_W-1:0]   par_blk_q;
	logic               has_right_q;
	logic [BLK_W-1:0]   l_blk_q;
	logic [BLK_W-1:0]   r_blk_q;
	logic [BLK_W-1:0]   child_blk_q;
	logic [STAMP_W-1:0] child_stamp_q;
	logic [BLK_W-1:0]   child_slot_q;
	logic [BLK_W-1:0]   res_victim_q;
	logic               res_err_q;
	logic               out_valid_q;
	logic [BLK_W-1:0]   victim_id_q;
	logic               error_q;
	logic [CNT_W-1:0]   free_count_q;

	logic               accept;
	logic               out_load;
	logic [CNT_W-1:0]   count_dec;
	logic [CNT_W-1:0]   c_full;
	logic [CNT_W-1:0]   c_plus;
	logic [BLK_W-1:0]   parent;
	logic [BLK_W-1:0]   rm_slot;
	logic               rm_go;
	logic               pick_r;

	logic               place_en;
	logic [BLK_W-1:0]   place_slot;
	logic [BLK_W-1:0]   place_blk;
	logic [BLK_W-1:0]   hs_ra;
	logic [BLK_W-1:0]   hs_rb;
	logic [BLK_W-1:0]   hs_a_rd;
	logic [BLK_W-1:0]   hs_b_rd;
	logic [BLK_W-1:0]   sob_rd;
	logic               inh_we;
	logic [BLK_W-1:0]   inh_wa;
	logic               inh_wd;
	logic               inh_rd;
	logic               lu_we;
	logic [BLK_W-1:0]   lu_wa;
	logic [STAMP_W-1:0] lu_wd;
	logic [BLK_W-1:0]   lu_ra;
	logic [BLK_W-1:0]   lu_rb;
	logic [STAMP_W-1:0] lu_a_rd;
	logic [STAMP_W-1:0] lu_b_rd;
	logic [STAMP_W-1:0] cmp_a;
	logic [STAMP_W-1:0] cmp_b;
	logic               cmp_lt;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign victim_id = victim_id_q;
	assign error     = error_q;
	assign free_count = free_count_q;

	assign count_dec = count_q - 1'b1;
	assign c_full    = {slot_q, 1'b1};
	assign c_plus    = c_full + 1'b1;
	assign parent    = (slot_q - 1'b1) >> 1;
	assign rm_slot   = (op_q == OP_TAKE) ? sob_rd : '0;
	assign rm_go     = ((op_q == OP_TAKE) && inh_rd) ||
		((op_q == OP_EVICT) && (count_q != '0));
	assign pick_r    = has_right_q && cmp_lt;

	// heap_slots: two copies give two read ports
	lvh_ram #(.WIDTH(BLK_W), .DEPTH(NUM_BLOCKS)) u_hs_a (
		.clk(clk), .we(place_en), .waddr(place_slot), .wdata(place_blk),
		.raddr(hs_ra), .rdata(hs_a_rd)
	);
	lvh_ram #(.WIDTH(BLK_W), .DEPTH(NUM_BLOCKS)) u_hs_b (
		.clk(clk), .we(place_en), .waddr(place_slot), .wdata(place_blk),
		.raddr(hs_rb), .rdata(hs_b_rd)
	);
	lvh_ram #(.WIDTH(BLK_W), .DEPTH(NUM_BLOCKS)) u_sob (
		.clk(clk), .we(place_en), .waddr(place_blk), .wdata(place_slot),
		.raddr(block_id), .rdata(sob_rd)
	);
	lvh_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_inh (
		.clk(clk), .we(inh_we), .waddr(inh_wa), .wdata(inh_wd),
		.raddr(block_id), .rdata(inh_rd)
	);
	lvh_ram #(.WIDTH(STAMP_W), .DEPTH(NUM_BLOCKS)) u_lu_a (
		.clk(clk), .we(lu_we), .waddr(lu_wa), .wdata(lu_wd),
		.raddr(lu_ra), .rdata(lu_a_rd)
	);
	lvh_ram #(.WIDTH(STAMP_W), .DEPTH(NUM_BLOCKS)) u_lu_b (
		.clk(clk), .we(lu_we), .waddr(lu_wa), .wdata(lu_wd),
		.raddr(lu_rb), .rdata(lu_b_rd)
	);

	lvh_age_cmp u_cmp (
		.stamp_a(cmp_a), .stamp_b(cmp_b), .use_clock(use_clock_q), .a_lt_b(cmp_lt)
	);

	always_comb begin
		place_en   = 1'b0;
		place_slot = slot_q;
		place_blk  = mv_blk_q;
		hs_ra      = '0;
		hs_rb      = '0;
		lu_ra      = '0;
		lu_rb      = '0;
		inh_we     = 1'b0;
		inh_wa     = blk_q;
		inh_wd     = 1'b0;
		lu_we      = 1'b0;
		lu_wa      = blk_q;
		lu_wd      = use_clock_q;
		cmp_a      = mv_stamp_q;
		cmp_b      = lu_a_rd;
		case (state_q)
			S_INIT: begin
				place_en   = 1'b1;
				place_slot = init_idx_q;
				place_blk  = init_idx_q;
				inh_we     = 1'b1;
				inh_wa     = init_idx_q;
				inh_wd     = 1'b1;
				lu_we      = 1'b1;
				lu_wa      = init_idx_q;
				lu_wd      = '0;
			end
			S_IDLE: begin
				// root for evict, old stamp for release
				hs_ra = '0;
				lu_ra = block_id;
			end
			S_CHECK: begin
				// fetch the last heap entry for a remove
				hs_ra = count_dec[BLK_W-1:0];
				case (op_q)
					OP_RELEASE: begin
						inh_we = !inh_rd;
						inh_wd = 1'b1;
						lu_we  = !inh_rd && stamp_q;
					end
					OP_TAKE: begin
						inh_we = inh_rd;
					end
					OP_EVICT: begin
						inh_we = (count_q != '0);
						inh_wa = hs_a_rd;
					end
					default: begin
					end
				endcase
			end
			S_LAST_RD: begin
				lu_ra = hs_a_rd;
			end
			S_UP: begin
				if (slot_q == '0) begin
					place_en = 1'b1;
				end else begin
					hs_ra = parent;
				end
			end
			S_UP_LU: begin
				lu_ra = hs_a_rd;
			end
			S_UP_CMP: begin
				place_en = 1'b1;
				if (cmp_lt) begin
					place_blk = par_blk_q;
				end
			end
			S_DN: begin
				hs_ra = c_full[BLK_W-1:0];
				hs_rb = c_plus[BLK_W-1:0];
				if (c_full >= count_q) begin
					place_en = 1'b1;
				end
			end
			S_DN_LU: begin
				lu_ra = hs_a_rd;
				lu_rb = hs_b_rd;
			end
			S_DN_SEL: begin
				// right child wins only when its key is strictly smaller
				cmp_a = lu_b_rd;
				cmp_b = lu_a_rd;
			end
			S_DN_CMP: begin
				cmp_a    = child_stamp_q;
				cmp_b    = mv_stamp_q;
				place_en = 1'b1;
				if (cmp_lt) begin
					place_blk = child_blk_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_idx_q  <= '0;
			use_clock_q <= '0;
			count_q     <= CNT_W'(NUM_BLOCKS);
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_idx_q <= init_idx_q + 1'b1;
					if (init_idx_q == BLK_W'(NUM_BLOCKS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					case (op_q)
						OP_RELEASE: begin
							if (inh_rd) begin
								state_q <= S_FIN;
							end else begin
								if (stamp_q) begin
									use_clock_q <= use_clock_q + 1'b1;
								end
								count_q <= count_q + 1'b1;
								state_q <= S_UP;
							end
						end
						OP_TAKE, OP_EVICT: begin
							if (rm_go) begin
								count_q <= count_dec;
								// removing the last slot needs no sift
								if ({1'b0, rm_slot} == count_dec) begin
									state_q <= S_FIN;
								end else begin
									state_q <= S_LAST_RD;
								end
							end else begin
								state_q <= S_FIN;
							end
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_LAST_RD: begin
					state_q <= S_LAST_LU;
				end
				S_LAST_LU: begin
					state_q <= S_UP;
				end
				S_UP: begin
					if (slot_q == '0) begin
						state_q <= (removing_q && !moved_q) ? S_DN : S_FIN;
					end else begin
						state_q <= S_UP_LU;
					end
				end
				S_UP_LU: begin
					state_q <= S_UP_CMP;
				end
				S_UP_CMP: begin
					if (cmp_lt) begin
						state_q <= S_UP;
					end else begin
						state_q <= (removing_q && !moved_q) ? S_DN : S_FIN;
					end
				end
				S_DN: begin
					state_q <= (c_full >= count_q) ? S_FIN : S_DN_LU;
				end
				S_DN_LU: begin
					state_q <= S_DN_SEL;
				end
				S_DN_SEL: begin
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					state_q <= cmp_lt ? S_DN : S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q         <= op_t'(op);
					blk_q        <= block_id;
					stamp_q      <= stamp_use;
					res_victim_q <= '0;
					res_err_q    <= 1'b0;
				end
			end
			S_CHECK: begin
				moved_q <= 1'b0;
				case (op_q)
					OP_RELEASE: begin
						res_err_q  <= inh_rd;
						removing_q <= 1'b0;
						slot_q     <= count_q[BLK_W-1:0];
						mv_blk_q   <= blk_q;
						mv_stamp_q <= stamp_q ? use_clock_q : lu_a_rd;
					end
					OP_EVICT: begin
						removing_q <= 1'b1;
						slot_q     <= rm_slot;
						if (count_q == '0) begin
							res_err_q <= 1'b1;
						end else begin
							res_victim_q <= hs_a_rd;
						end
					end
					default: begin
						removing_q <= 1'b1;
						slot_q     <= rm_slot;
					end
				endcase
			end
			S_LAST_RD: begin
				mv_blk_q <= hs_a_rd;
			end
			S_LAST_LU: begin
				mv_stamp_q <= lu_a_rd;
			end
			S_UP_LU: begin
				par_blk_q <= hs_a_rd;
			end
			S_UP_CMP: begin
				if (cmp_lt) begin
					slot_q  <= parent;
					moved_q <= 1'b1;
				end
			end
			S_DN: begin
				has_right_q <= (c_plus < count_q);
			end
			S_DN_LU: begin
				l_blk_q <= hs_a_rd;
				r_blk_q <= hs_b_rd;
			end
			S_DN_SEL: begin
				child_blk_q   <= pick_r ? r_blk_q : l_blk_q;
				child_stamp_q <= pick_r ? lu_b_rd : lu_a_rd;
				child_slot_q  <= pick_r ? c_plus[BLK_W-1:0] : c_full[BLK_W-1:0];
			end
			S_DN_CMP: begin
				if (cmp_lt) begin
					slot_q <= child_slot_q;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			victim_id_q  <= res_victim_q;
			error_q      <= res_err_q;
			free_count_q <= count_q;
		end
	end

endmodule

`default_nettype wire

// ----- sv/lvh_ram.sv -----
// Single write, single read RAM with registered read data
`default_nettype none

module lvh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- sv/lvh_age_cmp.sv -----
// Shared age comparator: stamps are keyed relative to the running use clock
`default_nettype none

module lvh_age_cmp import lvh_pkg::*; (
	input  wire logic [STAMP_W-1:0] stamp_a,
	input  wire logic [STAMP_W-1:0] stamp_b,
	input  wire logic [STAMP_W-1:0] use_clock,
	output logic                    a_lt_b
);

	logic [STAMP_W-1:0] key_a;
	logic [STAMP_W-1:0] key_b;

	// take keys modulo 2^32 so the order survives clock wraparound
	assign key_a  = stamp_a - use_clock;
	assign key_b  = stamp_b - use_clock;
	assign a_lt_b = key_a < key_b;

endmodule

`default_nettype wire

// ----- sv/lvh_checker.sv -----
// Port-level checks of the victim heap and their binding to the top level
`default_nettype none

`include "lru_victim_heap_defines.svh"

module lvh_checker import lvh_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic [1:0]       op,
	input wire logic [BLK_W-1:0] block_id,
	input wire logic             stamp_use,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [BLK_W-1:0] victim_id,
	input wire logic             error,
	input wire logic [CNT_W-1:0] free_count
);

	logic unused_ok;

	// payload of the input channel is watched by no check here
	assign unused_ok = ^{op, block_id, stamp_use};

	// hold a stalled result
	`LVH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(victim_id) && $stable(error) && $stable(free_count))

	// drop ready in the cycle after taking an item
	`LVH_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// never report more free blocks than the pool holds
	`LVH_ASSERT_NOW(a_count_range, clk, arst_n, out_valid, free_count <= CNT_W'(NUM_BLOCKS))

	// error results carry no victim
	`LVH_ASSERT_NOW(a_err_no_victim, clk, arst_n, out_valid && error, victim_id == '0)

endmodule

bind lru_victim_heap lvh_checker u_lvh_checker (.*);

`default_nettype wire

// ----- tb/tb_lru_victim_heap.sv -----
// Self-checking testbench of the LRU victim heap, with its own heap predictor
`default_nettype none

module tb_lru_victim_heap import lvh_pkg::*;;

	typedef struct packed {
		logic [BLK_W-1:0] victim;
		logic             err;
		logic [CNT_W-1:0] count;
	} heap_result_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [1:0]         op        = OP_NOP;
	logic [BLK_W-1:0]   block_id  = '0;
	logic               stamp_use = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [BLK_W-1:0]   victim_id;
	logic               error;
	logic [CNT_W-1:0]   free_count;

	// Predictor state
	logic [BLK_W-1:0]   heap_slot [NUM_BLOCKS];
	logic [BLK_W-1:0]   slot_pos  [NUM_BLOCKS];
	logic               is_free   [NUM_BLOCKS];
	logic [STAMP_W-1:0] stamp_of  [NUM_BLOCKS];
	logic [STAMP_W-1:0] use_clk;
	logic [CNT_W-1:0]   free_cnt;

	heap_result_t pending_results[$];
	int           mismatch_count = 0;
	bit           no_stall       = 1'b0;

	lru_victim_heap DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.block_id   (block_id),
		.stamp_use  (stamp_use),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.victim_id  (victim_id),
		.error      (error),
		.free_count (free_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [STAMP_W-1:0] age_of(logic [BLK_W-1:0] b);
		return stamp_of[b] - use_clk;
	endfunction

	function automatic void put_slot(int s, logic [BLK_W-1:0] b);
		heap_slot[s] = b;
		slot_pos[b]  = s[BLK_W-1:0];
	endfunction

	function automatic int rise(int s, logic [BLK_W-1:0] b);
		logic [STAMP_W-1:0] k;
		logic [BLK_W-1:0]   pb;
		int                 p;
		bit                 done;
		k    = age_of(b);
		done = 1'b0;
		while (s != 0 && !done) begin
			p  = (s - 1) >> 1;
			pb = heap_slot[p];
			if (k >= age_of(pb)) begin
				done = 1'b1;
			end else begin
				put_slot(s, pb);
				s = p;
			end
		end
		put_slot(s, b);
		return s;
	endfunction

	function automatic void sink(int s, logic [BLK_W-1:0] b);
		logic [STAMP_W-1:0] k;
		logic [BLK_W-1:0]   cb;
		int                 c;
		bit                 done;
		k    = age_of(b);
		done = 1'b0;
		while (!done) begin
			c = 2 * s + 1;
			if (c >= int'(free_cnt)) begin
				done = 1'b1;
			end else begin
				// right child only when its key is strictly smaller
				if (c + 1 < int'(free_cnt) && age_of(heap_slot[c]) > age_of(heap_slot[c + 1]))
					c++;
				cb = heap_slot[c];
				if (k <= age_of(cb)) begin
					done = 1'b1;
				end else begin
					put_slot(s, cb);
					s = c;
				end
			end
		end
		put_slot(s, b);
	endfunction

	function automatic void drop_block(logic [BLK_W-1:0] b);
		int               s;
		logic [BLK_W-1:0] last;
		s          = slot_pos[b];
		is_free[b] = 1'b0;
		free_cnt   = free_cnt - 1'b1;
		if (s != int'(free_cnt)) begin
			last = heap_slot[free_cnt];
			if (rise(s, last) == s)
				sink(s, last);
		end
	endfunction

	function automatic heap_result_t predict_item(op_t code, logic [BLK_W-1:0] b, logic stamp);
		heap_result_t r;
		r = '0;
		case (code)
			OP_RELEASE: begin
				if (is_free[b]) begin
					r.err = 1'b1;
				end else begin
					if (stamp) begin
						stamp_of[b] = use_clk;
						use_clk     = use_clk + 1'b1;
					end
					is_free[b] = 1'b1;
					free_cnt   = free_cnt + 1'b1;
					void'(rise(int'(free_cnt) - 1, b));
				end
			end
			OP_TAKE: begin
				if (is_free[b])
					drop_block(b);
			end
			OP_EVICT: begin
				if (free_cnt == 0) begin
					r.err = 1'b1;
				end else begin
					r.victim = heap_slot[0];
					drop_block(r.victim);
				end
			end
			default: ;
		endcase
		r.count = free_cnt;
		return r;
	endfunction

	// Find a block whose free flag matches; scan from a random start
	function automatic logic [BLK_W-1:0] pick_block(logic want_free);
		int start;
		int i;
		start = $urandom_range(0, NUM_BLOCKS - 1);
		i     = 0;
		while (i < NUM_BLOCKS && is_free[(start + i) % NUM_BLOCKS] != want_free)
			i++;
		return (i < NUM_BLOCKS) ? BLK_W'((start + i) % NUM_BLOCKS) : BLK_W'(start);
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic send_item(op_t code, logic [BLK_W-1:0] blk, logic stamp);
		int gap;
		gap = no_stall ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= code;
		block_id  <= blk;
		stamp_use <= stamp;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_item(code, blk, stamp));
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_reset_order();
		send_item(OP_RELEASE, 10'd0,    1'b1);
		send_item(OP_RELEASE, 10'd1023, 1'b0);
		send_item(OP_EVICT,   10'd1023, 1'b1);
		send_item(OP_EVICT,   10'd0,    1'b0);
		send_item(OP_TAKE,    10'd1023, 1'b0);
		send_item(OP_TAKE,    10'd1023, 1'b1);
		send_item(OP_TAKE,    10'd512,  1'b0);
		send_item(OP_NOP,     10'd1023, 1'b1);
		send_item(OP_NOP,     10'd0,    1'b0);
		send_item(OP_RELEASE, 10'd1023, 1'b1);
		send_item(OP_RELEASE, 10'd0,    1'b1);
		send_item(OP_RELEASE, 10'd512,  1'b0);
		send_item(OP_RELEASE, 10'd1,    1'b1);
		send_item(OP_RELEASE, 10'd1,    1'b1);
		send_item(OP_EVICT,   10'd0,    1'b0);
		send_item(OP_EVICT,   10'd0,    1'b0);
		send_item(OP_TAKE,    10'd1023, 1'b0);
		send_item(OP_RELEASE, 10'd1023, 1'b0);
		send_item(OP_EVICT,   10'd0,    1'b0);
		send_item(OP_EVICT,   10'd0,    1'b0);
	endtask

	task automatic test_drain_to_empty();
		while (free_cnt != 0) begin
			if ($urandom_range(0, 1))
				send_item(OP_EVICT, BLK_W'($urandom_range(0, NUM_BLOCKS - 1)), 1'($urandom_range(0, 1)));
			else
				send_item(OP_TAKE, pick_block(1'b1), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_empty_heap();
		send_item(OP_EVICT,   10'd0,    1'b0);
		send_item(OP_TAKE,    10'd1023, 1'b0);
		send_item(OP_NOP,     10'd512,  1'b1);
		send_item(OP_RELEASE, 10'd1023, 1'b1);
		send_item(OP_EVICT,   10'd0,    1'b0);
		send_item(OP_EVICT,   10'd0,    1'b0);
	endtask

	task automatic test_random_mix(int n_items);
		int target;
		int roll;
		for (int i = 0; i < n_items; i++) begin
			// steer the fill level toward a new target now and then
			if (i % 150 == 0) begin
				roll   = $urandom_range(0, 3);
				target = (roll == 0) ? 0 : (roll == 1) ? NUM_BLOCKS : $urandom_range(0, NUM_BLOCKS);
			end
			if (i == n_items / 2)
				wait_all_results();
			no_stall = (i >= n_items * 2 / 3 && i < n_items * 5 / 6);
			roll = $urandom_range(0, 99);
			if (roll < 8)
				send_item(op_t'($urandom_range(0, 3)), BLK_W'($urandom_range(0, NUM_BLOCKS - 1)),
					1'($urandom_range(0, 1)));
			else if (roll < 12)
				send_item(OP_RELEASE, pick_block(1'b1), 1'($urandom_range(0, 1)));
			else if (roll < 15)
				send_item(OP_TAKE, pick_block(1'b0), 1'($urandom_range(0, 1)));
			else if ((int'(free_cnt) < target) ? (roll < 80) : (roll < 35))
				send_item(OP_RELEASE, pick_block(1'b0), $urandom_range(0, 9) < 7);
			else if (roll % 2 == 0)
				send_item(OP_EVICT, BLK_W'($urandom_range(0, NUM_BLOCKS - 1)), 1'($urandom_range(0, 1)));
			else
				send_item(OP_TAKE, pick_block(1'b1), 1'($urandom_range(0, 1)));
		end
		no_stall = 1'b0;
	endtask

	// Receiver: random stall before each result item, none while no_stall is set
	initial begin : result_sink
		int gap;
		@(posedge clk);
		forever begin
			gap = no_stall ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : check_results
		heap_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result item with none expected: victim %0d error %0d count %0d",
					victim_id, error, free_count));
			end else begin
				want = pending_results.pop_front();
				if (victim_id !== want.victim)
					report_mismatch($sformatf("victim_id got %0d want %0d", victim_id, want.victim));
				if (error !== want.err)
					report_mismatch($sformatf("error got %0d want %0d", error, want.err));
				if (free_count !== want.count)
					report_mismatch($sformatf("free_count got %0d want %0d", free_count, want.count));
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			heap_slot[i] = BLK_W'(i);
			slot_pos[i]  = BLK_W'(i);
			is_free[i]   = 1'b1;
			stamp_of[i]  = '0;
		end
		use_clk  = '0;
		free_cnt = CNT_W'(NUM_BLOCKS);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_order();
		test_random_mix(150);
		test_drain_to_empty();
		test_empty_heap();

		wait_all_results();
		repeat (64) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+sv
sv/lvh_pkg.sv
sv/lvh_ram.sv
sv/lvh_age_cmp.sv
sv/lru_victim_heap.sv
sv/lvh_checker.sv
tb/tb_lru_victim_heap.sv
